// ===== rtl/core/valid_2d_convolution_macros.svh =====
// Assertion macros shared by the valid 2D convolution RTL.
`ifndef VALID_2D_CONVOLUTION_MACROS_SVH
`define VALID_2D_CONVOLUTION_MACROS_SVH

// check cons in the same cycle whenever ante holds
`define V2DC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante holds
`define V2DC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/v2dc_pkg.sv =====
// Types, sizes and codes of the valid 2D convolution block.
`timescale 1ns / 1ps

package v2dc_pkg;

  localparam int MAX_KERNEL = 7;
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;

  localparam int DIM_W      = 11;
  localparam int K_W        = 3;
  localparam int KIDX_W     = 3;
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 10;
  localparam int SUM_W      = 36;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int HIST_N     = MAX_KERNEL - 1;
  localparam int HIST_IDX_W = (HIST_N > 1) ? $clog2(HIST_N) : 1;
  localparam int LS_W       = HIST_N * PIX_W;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int ROWSUM_W   = PROD_W + $clog2(MAX_KERNEL + 1);

  localparam logic [K_W-1:0] K_RESET = K_W'(3);

  typedef enum logic {
    OP_COEF  = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_IMAGE_ROWS  = 2'd0,
    REG_IMAGE_COLS  = 2'd1,
    REG_KERNEL_SIZE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    op_e                      op;
    logic [KIDX_W-1:0]        coef_row;
    logic [KIDX_W-1:0]        coef_col;
    logic signed [COEF_W-1:0] coef_value;
    logic [PIX_W-1:0]         pixel;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [SUM_W-1:0] conv_sum;
    logic                    last_of_frame;
  } out_word_t;

endpackage

// ===== rtl/core/valid_2d_convolution.sv =====
// Top level: streaming valid KxK correlation with line store and window.
//
//   channel   direction  handshake                     word
//   in        input      in_valid_i / in_stall_o       in_word_i  (coef load or pixel)
//   out       output     out_valid_o / out_stall_i     out_word_o (position, sum, last)
//   cfg       input      cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// One word is accepted per cycle unless the output stalls.
// The rate is set by the single line store RAM port pair: one column read
// when a pixel enters and one write when it leaves the input stage.
// Reset clears control, positions and the kernel; the line store and window
// need no clearing pass. A stalled output back-pressures stage by stage.
`timescale 1ns / 1ps
`include "valid_2d_convolution_macros.svh"

module valid_2d_convolution (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  v2dc_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output v2dc_pkg::out_word_t  out_word_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [v2dc_pkg::DIM_W-1:0] cfg_wdata_i
);

  import v2dc_pkg::*;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // configuration
  logic [DIM_W-1:0] rows_q, cols_q;
  logic [K_W-1:0]   k_q;
  logic             cfg_hit;

  always_comb begin
    unique case (cfg_idx_i)
      REG_IMAGE_ROWS, REG_IMAGE_COLS, REG_KERNEL_SIZE: cfg_hit = cfg_we_i;
      default:                                         cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(MAX_ROWS);
      cols_q <= DIM_W'(MAX_COLS);
      k_q    <= K_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_ROWS:  rows_q <= clamp_dim(cfg_wdata_i, DIM_W'(MAX_ROWS));
        REG_IMAGE_COLS:  cols_q <= clamp_dim(cfg_wdata_i, DIM_W'(MAX_COLS));
        REG_KERNEL_SIZE: begin
          if (cfg_wdata_i[K_W-1:0] == '0) begin
            k_q <= K_W'(1);
          end else if (int'(cfg_wdata_i[K_W-1:0]) > MAX_KERNEL) begin
            k_q <= K_W'(MAX_KERNEL);
          end else begin
            k_q <= cfg_wdata_i[K_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // handshake chain
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic ready1, ready2, ready3, ready4;
  logic s1_move, in_accept, pix_acc;

  assign ready4    = !out_v_q || !out_stall_i;
  assign ready3    = !s3_v_q || ready4;
  assign ready2    = !s2_v_q || ready3;
  assign s1_move   = s1_v_q && ready2;
  assign ready1    = !s1_v_q || s1_move;
  assign in_stall_o = !ready1;
  assign in_accept = in_valid_i && ready1;
  assign pix_acc   = in_accept && (in_word_i.op == OP_PIXEL);

  // frame position
  logic [ROW_W-1:0] row_q, r_eff, orow_in;
  logic [COL_W-1:0] col_q, c_eff, ocol_in;
  logic [DIM_W-1:0] r_next, c_next;
  logic             emit_in, last_in;

  always_comb begin
    r_eff   = (DIM_W'(row_q) >= rows_q) ? '0 : row_q;
    c_eff   = (DIM_W'(col_q) >= cols_q) ? '0 : col_q;
    r_next  = DIM_W'(r_eff) + DIM_W'(1);
    c_next  = DIM_W'(c_eff) + DIM_W'(1);
    emit_in = (r_next >= DIM_W'(k_q)) && (c_next >= DIM_W'(k_q));
    last_in = (r_next == rows_q) && (c_next == cols_q);
    orow_in = ROW_W'(r_next - DIM_W'(k_q));
    ocol_in = COL_W'(c_next - DIM_W'(k_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_hit) begin
      row_q <= '0;
      col_q <= '0;
    end else if (pix_acc) begin
      if (c_next >= cols_q) begin
        col_q <= '0;
        row_q <= (r_next >= rows_q) ? '0 : ROW_W'(r_next);
      end else begin
        col_q <= COL_W'(c_next);
      end
    end
  end

  // input stage
  in_word_t         s1_word_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_orow_q;
  logic [COL_W-1:0] s1_ocol_q;
  logic             s1_emit_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (ready1) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_word_q <= in_word_i;
      s1_col_q  <= c_eff;
      s1_orow_q <= orow_in;
      s1_ocol_q <= ocol_in;
      s1_emit_q <= emit_in;
      s1_last_q <= last_in;
    end
  end

  // line store: per column, the pixels of the rows above
  logic             s1_pix, ram_we, byp_q;
  logic [LS_W-1:0]  ram_rdata, hist, hist_wr, byp_data_q;

  assign s1_pix  = s1_v_q && (s1_word_q.op == OP_PIXEL);
  assign ram_we  = s1_move && (s1_word_q.op == OP_PIXEL);

  v2dc_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_col_q),
    .wdata_i (hist_wr),
    .re_i    (pix_acc),
    .raddr_i (c_eff),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (pix_acc) begin
      byp_q <= ram_we && (s1_col_q == c_eff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      byp_data_q <= hist_wr;
    end
  end

  assign hist = byp_q ? byp_data_q : ram_rdata;

  generate
    if (HIST_N > 1) begin : g_hist_shift
      assign hist_wr = {hist[LS_W-PIX_W-1:0], s1_word_q.pixel};
    end else begin : g_hist_one
      assign hist_wr = s1_word_q.pixel;
    end
  endgenerate

  // kernel, window and products
  logic signed [COEF_W-1:0] coef_q [MAX_KERNEL][MAX_KERNEL];
  logic [PIX_W-1:0]         win_q  [MAX_KERNEL][MAX_KERNEL];
  logic [PIX_W-1:0]         win_d  [MAX_KERNEL][MAX_KERNEL];
  logic [PIX_W-1:0]         column [MAX_KERNEL];
  logic signed [PROD_W-1:0] prod_d [MAX_KERNEL][MAX_KERNEL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int x = 0; x < MAX_KERNEL; x++) begin
        for (int y = 0; y < MAX_KERNEL; y++) begin
          coef_q[x][y] <= '0;
        end
      end
    end else if (s1_move && (s1_word_q.op == OP_COEF)) begin
      for (int x = 0; x < MAX_KERNEL; x++) begin
        for (int y = 0; y < MAX_KERNEL; y++) begin
          if ((int'(s1_word_q.coef_row) == x) && (int'(s1_word_q.coef_col) == y)) begin
            coef_q[x][y] <= s1_word_q.coef_value;
          end
        end
      end
    end
  end

  always_comb begin
    int ny;
    for (int x = 0; x < MAX_KERNEL; x++) begin
      if (x == int'(k_q) - 1) begin
        column[x] = s1_word_q.pixel;
      end else if (x < int'(k_q) - 1) begin
        column[x] = hist[PIX_W * int'(HIST_IDX_W'(int'(k_q) - 2 - x)) +: PIX_W];
      end else begin
        column[x] = '0;
      end
    end
    for (int x = 0; x < MAX_KERNEL; x++) begin
      for (int y = 0; y < MAX_KERNEL; y++) begin
        ny = (y == MAX_KERNEL - 1) ? y : y + 1;
        if (y == int'(k_q) - 1) begin
          win_d[x][y] = column[x];
        end else if (y < int'(k_q) - 1) begin
          win_d[x][y] = win_q[x][ny];
        end else begin
          win_d[x][y] = win_q[x][y];
        end
        if ((x < int'(k_q)) && (y < int'(k_q))) begin
          prod_d[x][y] = $signed({1'b0, win_d[x][y]}) * coef_q[x][y];
        end else begin
          prod_d[x][y] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      win_q <= win_d;
    end
  end

  // product stage
  logic signed [PROD_W-1:0] s2_prod_q [MAX_KERNEL][MAX_KERNEL];
  logic [ROW_W-1:0]         s2_orow_q, s3_orow_q;
  logic [COL_W-1:0]         s2_ocol_q, s3_ocol_q;
  logic                     s2_last_q, s3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (ready2) begin
      s2_v_q <= s1_pix && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2) begin
      s2_prod_q <= prod_d;
      s2_orow_q <= s1_orow_q;
      s2_ocol_q <= s1_ocol_q;
      s2_last_q <= s1_last_q;
    end
  end

  // row sum stage
  logic signed [ROWSUM_W-1:0] rowsum_d  [MAX_KERNEL];
  logic signed [ROWSUM_W-1:0] s3_rsum_q [MAX_KERNEL];
  logic signed [SUM_W-1:0]    total_d;

  always_comb begin
    for (int x = 0; x < MAX_KERNEL; x++) begin
      rowsum_d[x] = '0;
      for (int y = 0; y < MAX_KERNEL; y++) begin
        rowsum_d[x] = rowsum_d[x] + ROWSUM_W'(s2_prod_q[x][y]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (ready3) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3) begin
      s3_rsum_q <= rowsum_d;
      s3_orow_q <= s2_orow_q;
      s3_ocol_q <= s2_ocol_q;
      s3_last_q <= s2_last_q;
    end
  end

  // output register
  out_word_t out_word_q;

  always_comb begin
    total_d = '0;
    for (int x = 0; x < MAX_KERNEL; x++) begin
      total_d = total_d + SUM_W'(s3_rsum_q[x]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ready4) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready4) begin
      out_word_q.out_row       <= POS_W'(s3_orow_q);
      out_word_q.out_col       <= POS_W'(s3_ocol_q);
      out_word_q.conv_sum      <= total_d;
      out_word_q.last_of_frame <= s3_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_word_q;

  `V2DC_ASSERT(a_empty_input_ready, !s1_v_q, !in_stall_o, "input stalled with empty input stage")
  `V2DC_ASSERT_NEXT(a_cfg_restart, cfg_hit, (row_q == '0) && (col_q == '0), "frame not restarted")
  `V2DC_ASSERT(a_col_in_range, 1'b1, DIM_W'(col_q) < cols_q, "column position out of range")

endmodule

// ===== rtl/core/v2dc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module v2dc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
